[rtl/core/aebd_pkg.sv]
// Shared constants, codes and types for the audio elastic buffer with drift correction.
// Used by aebd_ram, aebd_drift and audio_elastic_buffer_drift. Has no dependencies.
package aebd_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int FILL_W    = $clog2(BUF_BYTES + 1);
    localparam int CFG_W     = 13;
    localparam int PEND_W    = 10;
    localparam int PEND_MAX  = 1023;
    localparam int MAX_CHUNK = 64;
    localparam int NEED_W    = $clog2(2 * MAX_CHUNK + 1);
    localparam int WIDE_W0   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int WIDE_W    = ((WIDE_W0 > PEND_W) ? WIDE_W0 : PEND_W) + 1;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_FRAME     = 2'd2;
    localparam logic [1:0] REG_CHUNK     = 2'd3;

    // Correction codes.
    localparam logic [1:0] CORR_NONE   = 2'd0;
    localparam logic [1:0] CORR_SKIP   = 2'd1;
    localparam logic [1:0] CORR_REPEAT = 2'd2;

    // Item and result kinds.
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_READ    = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [1:0]        corr;
        logic [ADDR_W-1:0] rpos;
        logic [FILL_W-1:0] avail;
    } drift_t;

endpackage

[rtl/core/aebd_ram.sv]
// Byte ring store: one write port and one read port, read data registered.
// Depends on aebd_pkg for the depth and address width.
module aebd_ram
    import aebd_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [BUF_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/aebd_drift.sv]
// Drift: skip up to a frame above target plus threshold, step back a frame below
// target minus threshold when it fits. Depends on aebd_pkg for widths and codes.
module aebd_drift
    import aebd_pkg::*;
(
    input  logic [FILL_W-1:0] avail,
    input  logic [ADDR_W-1:0] rpos,
    input  logic [CFG_W-1:0]  aim_level,
    input  logic [CFG_W-1:0]  drift_margin,
    input  logic [4:0]        frame_bytes,
    output drift_t            drift
);

    logic [WIDE_W-1:0] avail_w;
    logic [WIDE_W-1:0] frame_w;
    logic [WIDE_W-1:0] upper;
    logic [WIDE_W-1:0] avail_plus_thr;
    logic [WIDE_W-1:0] avail_plus_frame;
    logic [WIDE_W-1:0] step;
    logic              do_skip;
    logic              do_repeat;

    always_comb
    begin
        avail_w          = WIDE_W'(avail);
        frame_w          = WIDE_W'(frame_bytes);
        upper            = WIDE_W'(aim_level) + WIDE_W'(drift_margin);
        avail_plus_thr   = avail_w + WIDE_W'(drift_margin);
        avail_plus_frame = avail_w + frame_w;
        step             = (frame_w < avail_w) ? frame_w : avail_w;
        do_skip          = avail_w > upper;
        // Below target minus threshold, written without a signed difference.
        do_repeat        = !do_skip && (avail_plus_thr < WIDE_W'(aim_level))
                           && (avail_plus_frame <= WIDE_W'(BUF_BYTES));

        drift.corr  = CORR_NONE;
        drift.rpos  = rpos;
        drift.avail = avail;
        if (do_skip)
        begin
            drift.corr  = CORR_SKIP;
            drift.rpos  = rpos + ADDR_W'(step);
            drift.avail = FILL_W'(avail_w - step);
        end
        else if (do_repeat)
        begin
            drift.corr  = CORR_REPEAT;
            drift.rpos  = rpos - ADDR_W'(frame_bytes);
            drift.avail = FILL_W'(avail_plus_frame);
        end
    end

endmodule

[rtl/core/audio_elastic_buffer_drift.sv]
// Audio elastic buffer with clock drift correction: top level, control sequencer.
// Depends on aebd_pkg, aebd_ram and aebd_drift.
//
// Items enter through start/busy: an item is taken at a clock edge with start high
// and busy low. action selects a packet byte write or a chunk read. A write's store
// update happens in S_WRITE, the cycle after acceptance, and a write that ends a
// packet puts one status result on the result ports in the next cycle. A chunk read
// steps through S_CORR for the drift correction, S_NEED for the fill check, then
// S_STREAM with one ring read per byte through the single read port of the store,
// whose data is registered; samples pair their bytes low first, and busy stays high
// until every byte of the chunk has been read. Each result is shown for one cycle
// with result_valid high; the receiver cannot hold results off, and the block never
// needs it to. Configuration is written through cfg_we, cfg_index and cfg_data; the
// user is to write it only while idle, as the block does not enforce this. After
// reset the ring store is cleared, one byte a cycle, which keeps busy high until the
// whole store is cleared; configuration writes are taken during that pass.
module audio_elastic_buffer_drift
    import aebd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [7:0]         data_byte,
    input  logic               packet_first,
    input  logic               packet_last,
    input  logic [9:0]         packet_length,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               result_valid,
    output logic               kind,
    output logic signed [15:0] sample,
    output logic               chunk_last,
    output logic               underrun,
    output logic [1:0]         correction,
    output logic               packet_dropped,
    output logic               ready_to_play,
    output logic [12:0]        fill_level
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_CORR,
        S_NEED,
        S_STREAM,
        S_DRAIN
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [CFG_W-1:0]  target_reg;
    logic [CFG_W-1:0]  thr_reg;
    logic [4:0]        frame_reg;
    logic [6:0]        chunk_reg;

    logic [ADDR_W-1:0] wpos_reg;
    logic [ADDR_W-1:0] rpos_reg;
    logic [FILL_W-1:0] avail_reg;
    logic              accepting_reg;
    logic [PEND_W-1:0] pend_reg;

    logic [7:0]        byte_reg;
    logic              first_reg;
    logic              last_reg;
    logic [9:0]        len_reg;

    logic [1:0]        corr_reg;
    logic              under_reg;
    logic [NEED_W-1:0] need_reg;
    logic [NEED_W-1:0] cnt_reg;
    logic              rd_vld_reg;
    logic              rd_hi_reg;
    logic              rd_last_reg;
    logic [7:0]        lo_byte_reg;

    logic              result_valid_reg;
    logic              kind_reg;
    logic [15:0]       sample_reg;
    logic              chunk_last_reg;
    logic              underrun_reg;
    logic [1:0]        correction_reg;
    logic              dropped_reg;
    logic              ready_reg;
    logic [12:0]       fill_reg;

    // Write path, worked out from the latched byte and the buffer state.
    logic [ADDR_W-1:0] w_rollback;
    logic [ADDR_W-1:0] w_addr;
    logic [WIDE_W-1:0] w_fits_sum;
    logic              w_acc1;
    logic [PEND_W-1:0] w_pend1;
    logic [WIDE_W-1:0] w_sum_p;
    logic              w_fail;
    logic              w_do;
    logic [ADDR_W-1:0] w_wpos2;
    logic [PEND_W-1:0] w_pend2;
    logic [FILL_W-1:0] w_avail_new;

    // Read path helpers.
    logic [6:0]        n_clamped;
    logic [NEED_W-1:0] need_calc;
    logic              need_under;
    drift_t            drift;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_q;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        // Bytes of an unfinished packet are taken back by rolling the write position.
        w_rollback = wpos_reg - ADDR_W'(pend_reg);
        w_fits_sum = WIDE_W'(avail_reg) + WIDE_W'(len_reg);
        w_acc1     = first_reg ? (w_fits_sum <= WIDE_W'(BUF_BYTES)) : accepting_reg;
        w_pend1    = first_reg ? '0 : pend_reg;
        w_addr     = first_reg ? w_rollback : wpos_reg;
        w_sum_p    = WIDE_W'(avail_reg) + WIDE_W'(w_pend1);
        w_fail     = w_acc1 && ((w_pend1 == PEND_W'(PEND_MAX))
                                || (w_sum_p >= WIDE_W'(BUF_BYTES)));
        w_do       = w_acc1 && !w_fail;
        if (w_fail)
        begin
            w_wpos2 = w_rollback;
        end
        else if (w_do)
        begin
            w_wpos2 = w_addr + ADDR_W'(1);
        end
        else
        begin
            w_wpos2 = w_addr;
        end
        w_pend2     = w_do ? (w_pend1 + PEND_W'(1)) : '0;
        w_avail_new = w_do ? FILL_W'(w_sum_p + WIDE_W'(1)) : avail_reg;
    end

    always_comb
    begin
        if (chunk_reg == 7'd0)
        begin
            n_clamped = 7'd1;
        end
        else if (chunk_reg > 7'(MAX_CHUNK))
        begin
            n_clamped = 7'(MAX_CHUNK);
        end
        else
        begin
            n_clamped = chunk_reg;
        end
        need_calc  = NEED_W'({n_clamped, 1'b0});
        need_under = WIDE_W'(avail_reg) < WIDE_W'(need_reg);
    end

    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_WRITE) && w_do);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : w_addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? 8'd0 : byte_reg;

    aebd_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rpos_reg),
        .rdata (ram_q)
    );

    aebd_drift u_drift (
        .avail        (avail_reg),
        .rpos         (rpos_reg),
        .aim_level    (target_reg),
        .drift_margin (thr_reg),
        .frame_bytes  (frame_reg),
        .drift        (drift)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            target_reg       <= CFG_W'(2048);
            thr_reg          <= CFG_W'(256);
            frame_reg        <= 5'd4;
            chunk_reg        <= 7'd48;
            wpos_reg         <= '0;
            rpos_reg         <= '0;
            avail_reg        <= '0;
            accepting_reg    <= 1'b0;
            pend_reg         <= '0;
            byte_reg         <= '0;
            first_reg        <= 1'b0;
            last_reg         <= 1'b0;
            len_reg          <= '0;
            corr_reg         <= CORR_NONE;
            under_reg        <= 1'b0;
            need_reg         <= '0;
            cnt_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            rd_hi_reg        <= 1'b0;
            rd_last_reg      <= 1'b0;
            lo_byte_reg      <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= KIND_STATUS;
            sample_reg       <= '0;
            chunk_last_reg   <= 1'b0;
            underrun_reg     <= 1'b0;
            correction_reg   <= CORR_NONE;
            dropped_reg      <= 1'b0;
            ready_reg        <= 1'b0;
            fill_reg         <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            rd_vld_reg       <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET:    target_reg <= cfg_data;
                    REG_THRESHOLD: thr_reg    <= cfg_data;
                    REG_FRAME:     frame_reg  <= cfg_data[4:0];
                    REG_CHUNK:     chunk_reg  <= cfg_data[6:0];
                    default:       target_reg <= target_reg;
                endcase
            end

            // Read data returns in the cycle after the address; bytes pair up low first.
            if (rd_vld_reg)
            begin
                if (!rd_hi_reg)
                begin
                    lo_byte_reg <= ram_q;
                end
                else
                begin
                    result_valid_reg <= 1'b1;
                    kind_reg         <= KIND_SAMPLE;
                    sample_reg       <= under_reg ? 16'd0 : {ram_q, lo_byte_reg};
                    chunk_last_reg   <= rd_last_reg;
                    underrun_reg     <= under_reg;
                    correction_reg   <= corr_reg;
                    dropped_reg      <= 1'b0;
                    ready_reg        <= WIDE_W'(avail_reg) >= WIDE_W'(target_reg);
                    fill_reg         <= 13'(avail_reg);
                end
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(BUF_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        byte_reg  <= data_byte;
                        first_reg <= packet_first;
                        last_reg  <= packet_last;
                        len_reg   <= packet_length;
                        state_reg <= (action == ACT_READ) ? S_CORR : S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    wpos_reg <= w_wpos2;
                    if (last_reg)
                    begin
                        avail_reg        <= w_avail_new;
                        accepting_reg    <= 1'b0;
                        pend_reg         <= '0;
                        result_valid_reg <= 1'b1;
                        kind_reg         <= KIND_STATUS;
                        sample_reg       <= 16'd0;
                        chunk_last_reg   <= 1'b0;
                        underrun_reg     <= 1'b0;
                        correction_reg   <= CORR_NONE;
                        dropped_reg      <= !w_do;
                        ready_reg        <= WIDE_W'(w_avail_new) >= WIDE_W'(target_reg);
                        fill_reg         <= 13'(w_avail_new);
                    end
                    else
                    begin
                        accepting_reg <= w_do;
                        pend_reg      <= w_pend2;
                    end
                    state_reg <= S_IDLE;
                end
                S_CORR:
                begin
                    rpos_reg  <= drift.rpos;
                    avail_reg <= drift.avail;
                    corr_reg  <= drift.corr;
                    need_reg  <= need_calc;
                    state_reg <= S_NEED;
                end
                S_NEED:
                begin
                    under_reg <= need_under;
                    if (!need_under)
                    begin
                        avail_reg <= FILL_W'(WIDE_W'(avail_reg) - WIDE_W'(need_reg));
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_STREAM;
                end
                S_STREAM:
                begin
                    // On underrun the position stays put and the samples come out as zero.
                    if (!under_reg)
                    begin
                        rpos_reg <= rpos_reg + ADDR_W'(1);
                    end
                    rd_vld_reg  <= 1'b1;
                    rd_hi_reg   <= cnt_reg[0];
                    rd_last_reg <= (cnt_reg == NEED_W'(need_reg - NEED_W'(1)));
                    cnt_reg     <= cnt_reg + NEED_W'(1);
                    if (cnt_reg == NEED_W'(need_reg - NEED_W'(1)))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign kind           = kind_reg;
    assign sample         = sample_reg;
    assign chunk_last     = chunk_last_reg;
    assign underrun       = underrun_reg;
    assign correction     = correction_reg;
    assign packet_dropped = dropped_reg;
    assign ready_to_play  = ready_reg;
    assign fill_level     = fill_reg;

    // A status result only ever follows the cycle that processed a write byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_STATUS)) |-> $past(state_reg == S_WRITE))
        else $error("status result without a preceding write step");

    // The committed fill never exceeds the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        WIDE_W'(avail_reg) <= WIDE_W'(BUF_BYTES))
        else $error("fill count beyond buffer size");

    // No bytes are pending unless a packet is being accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accepting_reg |-> (pend_reg == '0))
        else $error("pending bytes outside a packet");

    // The store is written only by the clearing pass or a write step.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_WRITE)))
        else $error("store write outside clear or write step");

    // Underrun chunks are silence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_SAMPLE) && underrun) |-> (sample == 16'sd0))
        else $error("nonzero sample in an underrun chunk");

endmodule

[verif/audio_elastic_buffer_drift_test.sv]
// Self-checking testbench for audio_elastic_buffer_drift: drives packet bytes and chunk reads,
// predicts every status and sample result and compares them as they appear.
// Depends on aebd_pkg and the audio_elastic_buffer_drift RTL.
module audio_elastic_buffer_drift_test
    import aebd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        logic        last;
        logic        under;
        logic [1:0]  corr;
        logic        dropped;
        logic        ready;
        logic [12:0] fill;
    } buffer_out_t;

    // Mirrors the ring, the fill count and the registers, and keeps the results still due.
    class playout_scoreboard;
        logic [7:0]  ring [BUF_BYTES];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned fill;
        int unsigned pend;
        bit          in_packet;
        int unsigned target;
        int unsigned threshold;
        int unsigned frame_len;
        int unsigned chunk_len;
        buffer_out_t due_q[$];
        int unsigned mismatches;
        int unsigned samples_seen;
        int unsigned status_seen;
        int unsigned skips;
        int unsigned repeats;
        int unsigned underruns;
        int unsigned drops;

        function new();
            foreach (ring[i])
                ring[i] = 8'h00;
            wr_ptr = 0;
            rd_ptr = 0;
            fill = 0;
            pend = 0;
            in_packet = 1'b0;
            target = 2048;
            threshold = 256;
            frame_len = 4;
            chunk_len = 48;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
            case (idx)
                REG_TARGET:    target    = val;
                REG_THRESHOLD: threshold = val;
                REG_FRAME:     frame_len = val[4:0];
                REG_CHUNK:     chunk_len = val[6:0];
                default:       ;
            endcase
        endfunction

        function void push_out(input logic k, input logic [15:0] s, input logic last,
                               input logic under, input logic [1:0] corr, input logic dropped);
            buffer_out_t r;
            r.kind = k;
            r.sample = s;
            r.last = last;
            r.under = under;
            r.corr = corr;
            r.dropped = dropped;
            r.ready = (fill >= target);
            r.fill = 13'(fill);
            due_q.push_back(r);
        endfunction

        // Rolls the write position back over the bytes of the unfinished packet.
        function void drop_partial();
            wr_ptr = (wr_ptr + BUF_BYTES - pend) % BUF_BYTES;
            pend = 0;
            in_packet = 1'b0;
        endfunction

        function void accept_item(input logic act, input logic [7:0] db, input logic pf,
                                  input logic pl, input logic [9:0] plen);
            int unsigned n;
            int unsigned need;
            int unsigned step;
            int          hi;
            int          lo;
            logic [1:0]  corr;
            logic        under;
            logic        dropped;
            logic [15:0] s;
            if (act == ACT_READ)
            begin
                n = (chunk_len == 0) ? 1 : ((chunk_len > MAX_CHUNK) ? MAX_CHUNK : chunk_len);
                need = 2 * n;
                hi = int'(target) + int'(threshold);
                lo = int'(target) - int'(threshold);
                corr = CORR_NONE;
                if (int'(fill) > hi)
                begin
                    step = (frame_len < fill) ? frame_len : fill;
                    rd_ptr = (rd_ptr + step) % BUF_BYTES;
                    fill -= step;
                    corr = CORR_SKIP;
                    skips++;
                end
                else if (int'(fill) < lo && fill + frame_len <= BUF_BYTES)
                begin
                    rd_ptr = (rd_ptr + BUF_BYTES - frame_len % BUF_BYTES) % BUF_BYTES;
                    fill += frame_len;
                    corr = CORR_REPEAT;
                    repeats++;
                end
                under = (fill < need);
                if (under)
                    underruns++;
                else
                    fill -= need;
                for (int i = 0; i < n; i++)
                begin
                    s = 16'h0000;
                    if (!under)
                    begin
                        s[7:0] = ring[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % BUF_BYTES;
                        s[15:8] = ring[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % BUF_BYTES;
                    end
                    push_out(KIND_SAMPLE, s, i == n - 1, under, corr, 1'b0);
                end
            end
            else
            begin
                if (pf)
                begin
                    if (in_packet)
                        drop_partial();
                    pend = 0;
                    in_packet = (fill + plen <= BUF_BYTES);
                end
                if (in_packet)
                begin
                    if (pend >= PEND_MAX || fill + pend + 1 > BUF_BYTES)
                        drop_partial();
                    else
                    begin
                        ring[wr_ptr] = db;
                        wr_ptr = (wr_ptr + 1) % BUF_BYTES;
                        pend++;
                    end
                end
                if (pl)
                begin
                    dropped = !in_packet;
                    if (in_packet)
                        fill += pend;
                    else
                        drops++;
                    in_packet = 1'b0;
                    pend = 0;
                    push_out(KIND_STATUS, 16'h0000, 1'b0, 1'b0, CORR_NONE, dropped);
                end
            end
        endfunction

        function string describe(input buffer_out_t r);
            return $sformatf({"kind=%0d sample=%h last=%0d under=%0d corr=%0d",
                              " drop=%0d ready=%0d fill=%0d"},
                             r.kind, r.sample, r.last, r.under, r.corr, r.dropped,
                             r.ready, r.fill);
        endfunction

        function void check_result(input buffer_out_t got);
            buffer_out_t want;
            if (got.kind === KIND_SAMPLE)
                samples_seen++;
            else
                status_seen++;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = due_q.pop_front();
            if (got.kind !== want.kind || got.sample !== want.sample || got.last !== want.last ||
                got.under !== want.under || got.corr !== want.corr ||
                got.dropped !== want.dropped || got.ready !== want.ready ||
                got.fill !== want.fill)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               action = ACT_WRITE;
    logic [7:0]         data_byte = 8'h00;
    logic               packet_first = 1'b0;
    logic               packet_last = 1'b0;
    logic [9:0]         packet_length = 10'd0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_TARGET;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               result_valid;
    logic               kind;
    logic signed [15:0] sample;
    logic               chunk_last;
    logic               underrun;
    logic [1:0]         correction;
    logic               packet_dropped;
    logic               ready_to_play;
    logic [12:0]        fill_level;

    playout_scoreboard sb;
    bit                sender_pauses = 1'b1;
    int unsigned       items_taken = 0;

    audio_elastic_buffer_drift dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .data_byte      (data_byte),
        .packet_first   (packet_first),
        .packet_last    (packet_last),
        .packet_length  (packet_length),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .kind           (kind),
        .sample         (sample),
        .chunk_last     (chunk_last),
        .underrun       (underrun),
        .correction     (correction),
        .packet_dropped (packet_dropped),
        .ready_to_play  (ready_to_play),
        .fill_level     (fill_level)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_result({kind, sample, chunk_last, underrun, correction, packet_dropped,
                             ready_to_play, fill_level});
    end

    task automatic send_item(input logic act, input logic [7:0] db, input logic pf,
                             input logic pl, input logic [9:0] plen);
        int gap;
        if (sender_pauses && $urandom_range(99) < 11)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        data_byte <= db;
        packet_first <= pf;
        packet_last <= pl;
        packet_length <= plen;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.accept_item(act, db, pf, pl, plen);
        items_taken++;
    endtask

    task automatic send_packet(input int len, input logic [9:0] decl, input bit closed);
        for (int i = 0; i < len; i++)
            send_item(ACT_WRITE, 8'($urandom), i == 0, closed && i == len - 1,
                      (i == 0) ? decl : 10'($urandom));
    endtask

    // Mostly whole packets with random bytes; reads are favored while the fill is above
    // target so that the level hovers where the drift correction acts.
    task automatic run_traffic(input int n_items, input int max_len);
        int taken;
        int len;
        int read_pct;
        int pick;
        taken = 0;
        while (taken < n_items)
        begin
            read_pct = (sb.fill > sb.target) ? 55 : 20;
            pick = $urandom_range(99);
            if (pick < read_pct)
            begin
                send_item(ACT_READ, 8'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
                taken++;
            end
            else if (pick < 94)
            begin
                len = $urandom_range(1, max_len);
                send_packet(len, ($urandom_range(3) == 0) ? 10'($urandom_range(1, 1023)) : 10'(len),
                            $urandom_range(15) != 0);
                taken += len;
            end
            else
                send_item(ACT_WRITE, 8'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
        end
    endtask

    // Lets every due result drain and the last write finish before registers change.
    task automatic settle();
        start <= 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input int t, input int th, input int fr, input int ch);
        write_reg(REG_TARGET, CFG_W'(t));
        write_reg(REG_THRESHOLD, CFG_W'(th));
        write_reg(REG_FRAME, CFG_W'(fr));
        write_reg(REG_CHUNK, CFG_W'(ch));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a read of the empty buffer repeats a frame yet still underruns.
        send_item(ACT_READ, 8'h00, 1'b0, 1'b0, 10'd0);
        // Bytes outside any packet are ignored; one that closes a packet reports a drop.
        send_item(ACT_WRITE, 8'h5A, 1'b0, 1'b0, 10'd0);
        send_item(ACT_WRITE, 8'hA5, 1'b0, 1'b1, 10'd0);
        send_item(ACT_WRITE, 8'hFF, 1'b1, 1'b1, 10'd1023);
        // More bytes than the declared length are kept while they fit.
        send_item(ACT_WRITE, 8'h00, 1'b1, 1'b0, 10'd1);
        send_item(ACT_WRITE, 8'h80, 1'b0, 1'b0, 10'h3FF);
        send_item(ACT_WRITE, 8'h7F, 1'b0, 1'b1, 10'd0);
        // A new first byte abandons the packet in progress.
        send_item(ACT_WRITE, 8'h11, 1'b1, 1'b0, 10'd2);
        send_item(ACT_WRITE, 8'h22, 1'b0, 1'b0, 10'd0);
        send_item(ACT_WRITE, 8'h33, 1'b1, 1'b0, 10'd2);
        send_item(ACT_WRITE, 8'h44, 1'b0, 1'b1, 10'd0);
        send_item(ACT_READ, 8'hC3, 1'b1, 1'b1, 10'h2AA);

        settle();
        program_regs(40, 8, 4, 4);
        run_traffic(60, 24);

        // No pauses here: skips that reach past the fill with target and threshold at zero.
        settle();
        sender_pauses = 1'b0;
        program_regs(0, 0, 16, 1);
        run_traffic(30, 12);
        sender_pauses = 1'b1;

        // Threshold above target, and a zero chunk size.
        settle();
        program_regs(16, 4096, 3, 0);
        run_traffic(30, 12);

        // Zero frame with corrections reported, and an oversized chunk size.
        settle();
        program_regs(70, 10, 0, 127);
        run_traffic(70, 48);

        settle();
        program_regs($urandom_range(0, 120), $urandom_range(0, 40), $urandom_range(1, 16),
                     $urandom_range(1, 16));
        run_traffic(30, 24);

        settle();
        program_regs(37, 1544, 9, 2);
        run_traffic(30, 16);

        settle();
        program_regs(2048, 256, 4, 48);
        run_traffic(25, 16);

        start <= 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d items taken; %0d samples and %0d packet results compared",
                 items_taken, sb.samples_seen, sb.status_seen);
        $display("%0d skipped and %0d repeated frames, %0d silent chunks, %0d dropped packets",
                 sb.skips, sb.repeats, sb.underruns, sb.drops);
        if (sb.mismatches == 0 && sb.due_q.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatching results", sb.mismatches);
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("run did not finish in time");
        $display("status: fail");
        $finish;
    end

endmodule
